FILE: sv/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// shared types and constants of the bitmap run allocator
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int MAX_BYTES_DEF = 512;
	localparam int MAP_W         = 10;
	localparam int INDEX_W       = 12;
	localparam int LEN_W         = 13;
	localparam int UNITS         = 8;
	localparam logic [MAP_W-1:0] MAP_BYTES_RST = 10'd512;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_TEST  = 2'd1,
		CMD_SCAN  = 2'd2,
		CMD_WRITE = 2'd3
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t          command;
		logic [INDEX_W-1:0] bit_index;
		logic               write_value;
		logic [LEN_W-1:0]   run_length;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] start_index;
		logic               bit_state;
	} rsp_t;

	// controller to run counter
	typedef struct packed {
		logic             init;
		logic             byte_vld;
		logic [LEN_W-1:0] len;
	} scan_ctl_t;

	// run counter to controller
	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] start_index;
	} scan_sts_t;

endpackage

FILE: sv/bra_ram.sv
// ----------------------------------------------------------------------------
// bra_ram
// generic single-port synchronous ram, registered read, read-first
// ----------------------------------------------------------------------------
module bra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic [ADDR_W-1:0] addr,
	input  logic              we,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: sv/bra_scan.sv
// ----------------------------------------------------------------------------
// bra_scan
// free run counter: one map byte a cycle on byte_vld, reports the first run
// ----------------------------------------------------------------------------
module bra_scan import bra_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scan_ctl_t               ctl,
	input  logic [UNITS-1:0]        byte_data,
	output scan_sts_t               sts
);

	logic [LEN_W-1:0] count_q;
	logic [LEN_W-1:0] base_q;
	logic [LEN_W-1:0] count_nx;
	logic [LEN_W-1:0] start_nx;
	logic             hit_nx;

	// walk the eight units of this byte, lsb first
	always_comb begin
		count_nx = count_q;
		start_nx = '0;
		hit_nx   = 1'b0;
		for (int j = 0; j < UNITS; j++) begin
			if (!hit_nx) begin
				if (byte_data[j]) begin
					count_nx = '0;
				end else begin
					count_nx = count_nx + LEN_W'(1);
				end
				if (count_nx == ctl.len) begin
					hit_nx   = 1'b1;
					start_nx = base_q + LEN_W'(j + 1) - ctl.len;
				end
			end
		end
	end

	assign sts.hit         = ctl.byte_vld & hit_nx;
	assign sts.start_index = start_nx[INDEX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q  <= '0;
		end else if (ctl.init) begin
			count_q <= '0;
			base_q  <= '0;
		end else if (ctl.byte_vld) begin
			count_q <= count_nx;
			base_q  <= base_q + LEN_W'(UNITS);
		end
	end

endmodule

FILE: sv/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// first-fit allocator over a bit map of allocation marks held in one ram
//
// channel   signals                       direction  transfer
// command   start, busy, cmd              in         start & !busy
// result    done, result                  out        done, one cycle, no stall
// config    cfg_valid, cfg_ready, cfg_data in        cfg_valid & cfg_ready
//
// after reset a clearing pass zeroes every ram entry, with busy high
// test and write: read the ram byte in the rmw state, write it back for write only;
// out-of-map indexes answer the next cycle
// clear: one byte per cycle over the bytes in use, result once the last is written
// scan: one byte per cycle, result on the first run found or after the last byte in use
// results go out on done for a single cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module bitmap_run_allocator import bra_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output rsp_t             result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [MAP_W-1:0] cfg_data
);

	localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int PTR_W  = ($clog2(MAX_BYTES + 1) > MAP_W + 1) ?
		$clog2(MAX_BYTES + 1) : MAP_W + 1;
	localparam logic [MAP_W-1:0] CAP =
		(MAX_BYTES > 1023) ? 10'd1023 : MAP_W'(MAX_BYTES);
	localparam logic [PTR_W-1:0] LAST_ENTRY = PTR_W'(MAX_BYTES - 1);

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_CLEAR = 5'b00100,
		S_RMW   = 5'b01000,
		S_SCAN  = 5'b10000
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	rsp_t             rsp_q;
	logic             done_q;
	logic [MAP_W-1:0] map_bytes_q;
	logic [PTR_W-1:0] ptr_q;
	logic             rd_vld_s1;

	logic [MAP_W-1:0]  in_use;
	logic [PTR_W-1:0]  in_use_ext;
	logic [LEN_W-1:0]  total_units;
	logic              accept;
	logic              in_oob;
	logic              q_oob;
	logic              scan_rd_en;
	logic [ADDR_W-1:0] ram_addr;
	logic              ram_we;
	logic [UNITS-1:0]  ram_wdata;
	logic [UNITS-1:0]  ram_rdata;
	logic [UNITS-1:0]  bit_mask;
	scan_ctl_t         scan_ctl;
	scan_sts_t         scan_sts;

	assign in_use      = (map_bytes_q > CAP) ? CAP : map_bytes_q;
	assign in_use_ext  = PTR_W'(in_use);
	assign total_units = {in_use, 3'b000};
	assign accept      = start & (state_q == S_IDLE);
	assign in_oob      = {1'b0, cmd.bit_index[INDEX_W-1:3]} >= in_use;
	assign q_oob       = {1'b0, cmd_q.bit_index[INDEX_W-1:3]} >= in_use;
	assign scan_rd_en  = (state_q == S_SCAN) & (ptr_q < in_use_ext) & ~scan_sts.hit;
	assign bit_mask    = UNITS'(1) << cmd_q.bit_index[2:0];

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = rsp_q;
	assign cfg_ready = 1'b1;

	// ram port select
	always_comb begin
		ram_addr  = ptr_q[ADDR_W-1:0];
		ram_we    = 1'b0;
		ram_wdata = '0;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_addr = ADDR_W'(cmd.bit_index[INDEX_W-1:3]);
			end
			S_RMW: begin
				ram_addr  = ADDR_W'(cmd_q.bit_index[INDEX_W-1:3]);
				ram_we    = (cmd_q.command == CMD_WRITE);
				ram_wdata = cmd_q.write_value ? (ram_rdata | bit_mask) :
					(ram_rdata & ~bit_mask);
			end
			S_SCAN: begin
				ram_addr = ptr_q[ADDR_W-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign scan_ctl.init     = accept & (cmd.command == CMD_SCAN);
	assign scan_ctl.byte_vld = rd_vld_s1;
	assign scan_ctl.len      = cmd_q.run_length;

	bra_ram #(
		.WIDTH (UNITS),
		.DEPTH (MAX_BYTES)
	) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	bra_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.byte_data (ram_rdata),
		.sts       (scan_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_bytes_q <= MAP_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			map_bytes_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			ptr_q     <= '0;
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= scan_rd_en;
			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + PTR_W'(1);
					if (ptr_q == LAST_ENTRY) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						unique case (cmd.command)
							CMD_CLEAR: begin
								if (in_use == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_CLEAR;
								end
							end
							CMD_TEST, CMD_WRITE: begin
								if (in_oob) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_RMW;
								end
							end
							CMD_SCAN: begin
								if (cmd.run_length == '0 || cmd.run_length > total_units) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_CLEAR: begin
					ptr_q <= ptr_q + PTR_W'(1);
					if (ptr_q + PTR_W'(1) == in_use_ext) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RMW: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_rd_en) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
					if (scan_sts.hit) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!rd_vld_s1 && ptr_q == in_use_ext) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rsp_q.found       <= (cmd.command != CMD_SCAN);
				rsp_q.start_index <= '0;
				rsp_q.bit_state   <= 1'b0;
			end
			S_RMW: begin
				rsp_q.found       <= 1'b1;
				rsp_q.start_index <= '0;
				rsp_q.bit_state   <= (cmd_q.command == CMD_TEST) & ~q_oob &
					ram_rdata[cmd_q.bit_index[2:0]];
			end
			S_SCAN: begin
				rsp_q.found       <= scan_sts.hit;
				rsp_q.start_index <= scan_sts.hit ? scan_sts.start_index : '0;
				rsp_q.bit_state   <= 1'b0;
			end
			default: begin
				rsp_q.found       <= 1'b1;
				rsp_q.start_index <= '0;
				rsp_q.bit_state   <= 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_notfound_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> cmd_q.command == CMD_SCAN)
		else $error("not-found result for a non-scan command");

	a_bitstate_test: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.bit_state |-> cmd_q.command == CMD_TEST)
		else $error("bit_state set for a non-test command");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_sts.hit |-> state_q == S_SCAN)
		else $error("run hit outside a scan");

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_INIT || state_q == S_CLEAR || state_q == S_RMW)
		else $error("ram write outside clear or modify");

	a_start_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.start_index == '0)
		else $error("start_index nonzero with no run found");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bitmap run allocator: directed corner commands,
// then phases of random and allocate-after-scan traffic over many map sizes,
// every result checked in order against a behavioral model of the mark map
// ----------------------------------------------------------------------------
module testbench import bra_pkg::*;;

	localparam int MAP_LIMIT      = MAX_BYTES_DEF;
	localparam int MARK_AW        = $clog2(MAP_LIMIT);
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = MAX_BYTES_DEF + 8;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 96;

	class alloc_scoreboard;
		logic [7:0]  marks [MAP_LIMIT];
		logic [MAP_W-1:0] map_size;
		rsp_t        expected_q [$];
		int unsigned errors, checked;
		int unsigned n_scan, n_found, n_test, n_write, n_clear;
		bit          last_found;
		int unsigned last_start;

		function new();
			foreach (marks[i]) marks[i] = 8'h00;
			map_size = MAP_BYTES_RST;
		endfunction

		function int unsigned used_bytes();
			return (32'(map_size) > MAP_LIMIT) ? MAP_LIMIT : 32'(map_size);
		endfunction

		function void set_map(logic [MAP_W-1:0] v);
			map_size = v;
		endfunction

		function bit read_mark(int unsigned unit);
			if (unit / UNITS >= used_bytes())
				return 1'b0;
			return marks[MARK_AW'(unit / UNITS)][3'(unit % UNITS)];
		endfunction

		// lowest start of len free units, whole-byte skip over full bytes
		function bit find_free_run(int unsigned len, output int unsigned first);
			int unsigned total, unit, count;
			total = used_bytes() * UNITS;
			count = 0;
			first = 0;
			if (len == 0 || len > total)
				return 1'b0;
			for (unit = 0; unit < total; unit++) begin
				if (unit % UNITS == 0 && marks[MARK_AW'(unit / UNITS)] == 8'hff) begin
					count = 0;
					unit += UNITS - 1;
					continue;
				end
				if (!read_mark(unit))
					count++;
				else
					count = 0;
				if (count == len) begin
					first = unit + 1 - len;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_command(cmd_t c);
			rsp_t        want;
			int unsigned first, byte_no;
			want.found       = 1'b1;
			want.start_index = '0;
			want.bit_state   = 1'b0;
			byte_no          = 32'(c.bit_index) / UNITS;
			case (c.command)
				CMD_CLEAR: begin
					n_clear++;
					for (int i = 0; i < used_bytes(); i++) marks[MARK_AW'(i)] = 8'h00;
				end
				CMD_TEST: begin
					n_test++;
					want.bit_state = read_mark(32'(c.bit_index));
				end
				CMD_SCAN: begin
					n_scan++;
					want.found       = find_free_run(32'(c.run_length), first);
					want.start_index = first[INDEX_W-1:0];
					last_found       = want.found;
					last_start       = first;
					if (want.found)
						n_found++;
				end
				default: begin
					n_write++;
					if (byte_no < used_bytes())
						marks[MARK_AW'(byte_no)][c.bit_index[2:0]] = c.write_value;
				end
			endcase
			expected_q.push_back(want);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result word with nothing pending (%p)", got));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.found !== want.found)
				report($sformatf("found %b, want %b", got.found, want.found));
			if (got.start_index !== want.start_index)
				report($sformatf("start_index %0d, want %0d",
					got.start_index, want.start_index));
			if (got.bit_state !== want.bit_state)
				report($sformatf("bit_state %b, want %b", got.bit_state, want.bit_state));
		endtask

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             done;
	rsp_t             result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [MAP_W-1:0] cfg_data;

	alloc_scoreboard sb = new();
	int unsigned     idle_pct;
	int unsigned     quiet_cycles;
	int unsigned     items_sent;

	bitmap_run_allocator #(.MAX_BYTES(MAP_LIMIT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// result check first, then note the word accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_command(cmd);
			if (cfg_valid && cfg_ready)
				sb.set_map(cfg_data);
			if (done || (start && !busy) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	function cmd_t make_cmd(cmd_code_t op, int unsigned idx, bit val, int unsigned len);
		cmd_t c;
		c.command     = op;
		c.bit_index   = idx[INDEX_W-1:0];
		c.write_value = val;
		c.run_length  = len[LEN_W-1:0];
		return c;
	endfunction

	task issue(cmd_t c);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			while ($urandom_range(99) < idle_pct) @(posedge clk);
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task write_map_size(logic [MAP_W-1:0] v);
		drain();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function int unsigned pick_index();
		int unsigned total;
		total = sb.used_bytes() * UNITS;
		if (total == 0 || $urandom_range(9) == 0)
			return $urandom_range(4095);
		return $urandom_range(total - 1);
	endfunction

	function int unsigned pick_length();
		int unsigned total, r;
		total = sb.used_bytes() * UNITS;
		r     = $urandom_range(99);
		if (r < 55)
			return $urandom_range(16, 1);
		if (r < 80)
			return $urandom_range(total + 8, 1);
		if (r < 88)
			return total + $urandom_range(1);
		if (r < 94)
			return 0;
		return $urandom_range(8191);
	endfunction

	task random_item();
		int unsigned r, len, first;
		r = $urandom_range(99);
		if (r < 30) begin
			issue(make_cmd(CMD_SCAN, $urandom, 1'($urandom), pick_length()));
		end else if (r < 52) begin
			issue(make_cmd(CMD_WRITE, pick_index(), $urandom_range(99) < 65, $urandom));
		end else if (r < 70) begin
			issue(make_cmd(CMD_TEST, pick_index(), 1'($urandom), $urandom));
		end else if (r < 80) begin
			// allocate: scan, wait for the answer, then mark the run
			len = $urandom_range(12, 1);
			issue(make_cmd(CMD_SCAN, $urandom, 1'($urandom), len));
			drain();
			if (sb.last_found) begin
				for (int k = 0; k < len; k++)
					issue(make_cmd(CMD_WRITE, sb.last_start + k, 1'b1, $urandom));
			end
		end else if (r < 90) begin
			// fill or free a block of consecutive units
			first = pick_index();
			len   = $urandom_range(24, 1);
			r     = ($urandom_range(99) < 60) ? 1 : 0;
			for (int k = 0; k < len; k++)
				issue(make_cmd(CMD_WRITE, first + k, r[0], $urandom));
		end else if (r < 93) begin
			issue(make_cmd(CMD_CLEAR, $urandom, 1'($urandom), $urandom));
		end else begin
			issue(cmd_t'($urandom));
		end
		if ($urandom_range(49) == 0)
			drain();
	endtask

	initial begin
		int unsigned sizes [PHASES];
		int unsigned idles [3];
		int unsigned phase_start;
		sizes = '{512, 1, 0, 1023, 64, 2, 512, 33, 300, 8, 700, 0};
		idles = '{0, 88, 31};
		sizes[PHASES-1] = $urandom_range(40, 1);
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		idle_pct     = 0;
		quiet_cycles = 0;
		items_sent   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// corner commands on the reset-size map
		issue(make_cmd(CMD_TEST, 0, 0, 0));
		issue(make_cmd(CMD_WRITE, 0, 1, 0));
		issue(make_cmd(CMD_WRITE, 4095, 1, 0));
		issue(make_cmd(CMD_TEST, 0, 0, 0));
		issue(make_cmd(CMD_TEST, 4095, 0, 0));
		issue(make_cmd(CMD_TEST, 4094, 0, 0));
		issue(make_cmd(CMD_SCAN, 0, 0, 0));
		issue(make_cmd(CMD_SCAN, 0, 0, 1));
		issue(make_cmd(CMD_SCAN, 0, 0, 4094));
		issue(make_cmd(CMD_SCAN, 0, 0, 4095));
		issue(make_cmd(CMD_SCAN, 0, 0, 4096));
		issue(make_cmd(CMD_SCAN, 4095, 1, 8191));
		issue(make_cmd(CMD_WRITE, 4095, 0, 0));
		issue(make_cmd(CMD_SCAN, 0, 0, 4095));
		for (int b = 8; b < 16; b++)
			issue(make_cmd(CMD_WRITE, b, 1, 0));
		issue(make_cmd(CMD_SCAN, 0, 0, 8));
		issue(make_cmd(CMD_CLEAR, 0, 0, 0));
		issue(make_cmd(CMD_TEST, 0, 0, 0));

		for (int p = 0; p < PHASES; p++) begin
			write_map_size(sizes[p][MAP_W-1:0]);
			idle_pct    = idles[p % 3];
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				random_item();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		$display("checked %0d results: %0d scans (%0d found), %0d tests, %0d writes, %0d clears",
			sb.checked, sb.n_scan, sb.n_found, sb.n_test, sb.n_write, sb.n_clear);
		$display("map sizes 0 to 1023 bytes, sender idle at 0, 31 and 88 percent");
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
sv/bra_pkg.sv
sv/bra_ram.sv
sv/bra_scan.sv
sv/bitmap_run_allocator.sv
bench/testbench.sv
